// ----- src/qp2c_pkg.sv -----
// Shared types and constants for the quaternion pose to camera-to-world unit.
// No dependencies; the other design files refer to this package by scoped name.
package qp2c_pkg;

  localparam int unsigned DIV_STEPS = 31;
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;
  localparam logic signed [31:0] QUAT_LIMIT = 32'sd1073741824;
  localparam logic [63:0] ROUND_HALF = 64'd268435456;

  typedef logic [63:0] u64_t;
  typedef logic signed [63:0] s64_t;
  typedef logic signed [31:0] s32_t;

  typedef struct packed {
    logic [1:0] row;
    logic       degen;
    s32_t       tx;
    s32_t       ty;
    s32_t       tz;
  } qp2c_tag_t;

endpackage

// ----- src/quat_pose_to_cam_to_world_unit.sv -----
// Top level of the quaternion pose to camera-to-world row generator.
// Depends on qp2c_pkg, qp2c_front, qp2c_div and qp2c_back.
//
// Channel  Dir  Payload                                            Per pose
// in_      in   quat w,x,y,z Q2.29 and trans x,y,z Q16.16          1 transaction
// out_     out  row, three rotation entries, translation, flags    3 transactions
//
// A pose is accepted only when the input row sequencer is idle or leaves its last row.
// The sequencer issues one row per cycle while out_tready does not stall, so the output
// then sustains one row per cycle, through front, 31-stage divider and back registers.
// Reset clears every valid bit and the sequencer; payload registers are not reset.
// A stall on out_tready freezes all stages together; nothing is lost or repeated.
module quat_pose_to_cam_to_world_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,   // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // row_index, rot_col0, rot_col1, rot_col2, trans_out, zeros
  output logic [0:0]   out_tuser,  // degenerate
  output logic         out_tlast
);

  logic                 en;
  logic                 f_vld, d_vld;
  qp2c_pkg::qp2c_tag_t  f_tag, d_tag;
  logic [2:0][63:0]     f_mag;
  logic [2:0]           f_neg, d_neg;
  logic [63:0]          f_den;
  logic [2:0][30:0]     d_quo;

  assign en = !out_tvalid || out_tready;

  qp2c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .vld       (f_vld),
    .tag       (f_tag),
    .num_mag   (f_mag),
    .num_neg   (f_neg),
    .den       (f_den)
  );

  qp2c_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .in_tag  (f_tag),
    .in_mag  (f_mag),
    .in_neg  (f_neg),
    .in_den  (f_den),
    .out_vld (d_vld),
    .out_tag (d_tag),
    .out_quo (d_quo),
    .out_neg (d_neg)
  );

  qp2c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (d_vld),
    .in_tag     (d_tag),
    .in_quo     (d_quo),
    .in_neg     (d_neg),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/qp2c_front.sv -----
// Pose intake, row sequencer, quaternion prescale, products and column numerators.
// Depends on qp2c_pkg.
module qp2c_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [223:0]         in_tdata,
  output logic                 vld,
  output qp2c_pkg::qp2c_tag_t  tag,
  output logic [2:0][63:0]     num_mag,
  output logic [2:0]           num_neg,
  output logic [63:0]          den
);

  logic         busy_r;
  logic [1:0]   cnt_r;
  logic [223:0] pose_r;
  logic         accept;

  logic                  v1_r;
  qp2c_pkg::s32_t        q1_r [4];
  qp2c_pkg::qp2c_tag_t   tag1_r;
  qp2c_pkg::s32_t        qs [4];
  logic                  big;

  logic                  v2_r;
  qp2c_pkg::s64_t        sq_r [4];
  qp2c_pkg::s64_t        xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  qp2c_pkg::qp2c_tag_t   tag2_r;

  qp2c_pkg::s64_t        nm [3];
  qp2c_pkg::u64_t        n2;

  logic                  v3_r;
  qp2c_pkg::qp2c_tag_t   tag3_r;
  logic [2:0][63:0]      mag3_r;
  logic [2:0]            neg3_r;
  logic [63:0]           den3_r;

  assign in_tready = !busy_r || (en && cnt_r == qp2c_pkg::ROW_LAST);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= qp2c_pkg::ROW_FIRST;
    end else if (accept) begin
      busy_r <= 1'b1;
      cnt_r  <= qp2c_pkg::ROW_FIRST;
    end else if (en && busy_r) begin
      if (cnt_r == qp2c_pkg::ROW_LAST) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pose_r <= in_tdata;
    end
  end

  always_comb begin
    big = 1'b0;
    for (int k = 0; k < 4; k++) begin
      qs[k] = pose_r[32*k +: 32];
      if (qs[k] > qp2c_pkg::QUAT_LIMIT || qs[k] < -qp2c_pkg::QUAT_LIMIT) begin
        big = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= busy_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        q1_r[k] <= big ? (qs[k] >>> 1) : qs[k];
      end
      tag1_r.row   <= cnt_r;
      tag1_r.degen <= 1'b0;
      tag1_r.tx    <= pose_r[159:128];
      tag1_r.ty    <= pose_r[191:160];
      tag1_r.tz    <= pose_r[223:192];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= 64'(q1_r[k]) * 64'(q1_r[k]);
      end
      xy_r   <= 64'(q1_r[1]) * 64'(q1_r[2]);
      wz_r   <= 64'(q1_r[0]) * 64'(q1_r[3]);
      xz_r   <= 64'(q1_r[1]) * 64'(q1_r[3]);
      wy_r   <= 64'(q1_r[0]) * 64'(q1_r[2]);
      yz_r   <= 64'(q1_r[2]) * 64'(q1_r[3]);
      wx_r   <= 64'(q1_r[0]) * 64'(q1_r[1]);
      tag2_r <= tag1_r;
    end
  end

  always_comb begin
    n2 = 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]) + 64'(sq_r[3]);
    case (tag2_r.row)
      2'd0: begin
        nm[0] = sq_r[0] + sq_r[1] - sq_r[2] - sq_r[3];
        nm[1] = (xy_r + wz_r) <<< 1;
        nm[2] = (xz_r - wy_r) <<< 1;
      end
      2'd1: begin
        nm[0] = (xy_r - wz_r) <<< 1;
        nm[1] = sq_r[0] - sq_r[1] + sq_r[2] - sq_r[3];
        nm[2] = (yz_r + wx_r) <<< 1;
      end
      default: begin
        nm[0] = (xz_r + wy_r) <<< 1;
        nm[1] = (yz_r - wx_r) <<< 1;
        nm[2] = sq_r[0] - sq_r[1] - sq_r[2] + sq_r[3];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        neg3_r[k] <= nm[k][63];
        mag3_r[k] <= nm[k][63] ? 64'(-nm[k]) : 64'(nm[k]);
      end
      den3_r <= n2;
      tag3_r <= '{row: tag2_r.row, degen: (n2 == 64'd0),
                  tx: tag2_r.tx, ty: tag2_r.ty, tz: tag2_r.tz};
    end
  end

  assign vld     = v3_r;
  assign tag     = tag3_r;
  assign num_mag = mag3_r;
  assign num_neg = neg3_r;
  assign den     = den3_r;

endmodule

// ----- src/qp2c_div.sv -----
// Three-lane restoring divider pipeline, one quotient bit per stage.
// Depends on qp2c_pkg.
module qp2c_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  qp2c_pkg::qp2c_tag_t  in_tag,
  input  logic [2:0][63:0]     in_mag,
  input  logic [2:0]           in_neg,
  input  logic [63:0]          in_den,
  output logic                 out_vld,
  output qp2c_pkg::qp2c_tag_t  out_tag,
  output logic [2:0][30:0]     out_quo,
  output logic [2:0]           out_neg
);

  localparam int unsigned N = qp2c_pkg::DIV_STEPS;

  logic                 vld_r [N];
  qp2c_pkg::qp2c_tag_t  tag_r [N];
  logic [2:0][63:0]     rem_r [N];
  logic [2:0][30:0]     quo_r [N];
  logic [2:0]           neg_r [N];
  logic [63:0]          den_r [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic                 v_in;
    qp2c_pkg::qp2c_tag_t  t_in;
    logic [2:0][63:0]     r_in;
    logic [2:0][30:0]     q_in;
    logic [2:0]           n_in;
    logic [63:0]          d_in;
    logic [2:0][63:0]     r_nxt;
    logic [2:0][30:0]     q_nxt;
    logic [63:0]          rs;

    if (j == 0) begin : g_head
      assign v_in = in_vld;
      assign t_in = in_tag;
      assign r_in = in_mag;
      assign q_in = '0;
      assign n_in = in_neg;
      assign d_in = in_den;
    end else begin : g_body
      assign v_in = vld_r[j-1];
      assign t_in = tag_r[j-1];
      assign r_in = rem_r[j-1];
      assign q_in = quo_r[j-1];
      assign n_in = neg_r[j-1];
      assign d_in = den_r[j-1];
    end

    always_comb begin
      rs = '0;
      for (int k = 0; k < 3; k++) begin
        rs       = (j == 0) ? r_in[k] : {r_in[k][62:0], 1'b0};
        q_nxt[k] = (j == 0) ? q_in[k] : {q_in[k][29:0], 1'b0};
        if (rs >= d_in) begin
          q_nxt[k][0] = 1'b1;
          r_nxt[k]    = rs - d_in;
        end else begin
          r_nxt[k]    = rs;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[j] <= t_in;
        rem_r[j] <= r_nxt;
        quo_r[j] <= q_nxt;
        neg_r[j] <= n_in;
        den_r[j] <= d_in;
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_tag = tag_r[N-1];
  assign out_quo = quo_r[N-1];
  assign out_neg = neg_r[N-1];

endmodule

// ----- src/qp2c_back.sv -----
// Rotation rounding, translation products, sum and saturating output register.
// Depends on qp2c_pkg.
module qp2c_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  qp2c_pkg::qp2c_tag_t  in_tag,
  input  logic [2:0][30:0]     in_quo,
  input  logic [2:0]           in_neg,
  output logic                 out_tvalid,
  output logic [135:0]         out_tdata,
  output logic [0:0]           out_tuser,
  output logic                 out_tlast
);

  logic                 va_r, vb_r, vc_r, vo_r;
  qp2c_pkg::qp2c_tag_t  ta_r, tb_r, tc_r;
  qp2c_pkg::s32_t       rot_a_r [3];
  qp2c_pkg::s32_t       rot_b_r [3];
  qp2c_pkg::s32_t       rot_c_r [3];
  qp2c_pkg::s64_t       prod_r [3];
  qp2c_pkg::s64_t       sum_r;
  logic [31:0]          rnd [3];

  logic [63:0]          smag;
  logic [35:0]          m;
  qp2c_pkg::s32_t       res;
  logic [135:0]         data_r;
  logic                 degen_r, last_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = ({1'b0, in_quo[k]} + 32'd1) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vo_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (in_tag.degen) begin
          rot_a_r[k] <= '0;
        end else begin
          rot_a_r[k] <= in_neg[k] ? -$signed(rnd[k]) : $signed(rnd[k]);
        end
      end
      ta_r      <= in_tag;
      prod_r[0] <= 64'(rot_a_r[0]) * 64'(ta_r.tx);
      prod_r[1] <= 64'(rot_a_r[1]) * 64'(ta_r.ty);
      prod_r[2] <= 64'(rot_a_r[2]) * 64'(ta_r.tz);
      rot_b_r   <= rot_a_r;
      tb_r      <= ta_r;
      sum_r     <= prod_r[0] + prod_r[1] + prod_r[2];
      rot_c_r   <= rot_b_r;
      tc_r      <= tb_r;
    end
  end

  always_comb begin
    smag = sum_r[63] ? 64'(-sum_r) : 64'(sum_r);
    m    = 36'((smag + qp2c_pkg::ROUND_HALF) >> 29);
    if (!sum_r[63]) begin
      res = (m > 36'h080000000) ? 32'sh80000000 : -$signed(m[31:0]);
    end else begin
      res = (m > 36'h07fffffff) ? 32'sh7fffffff : $signed(m[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r  <= {6'd0, res, -rot_c_r[2], -rot_c_r[1], rot_c_r[0], tc_r.row};
      degen_r <= tc_r.degen;
      last_r  <= (tc_r.row == qp2c_pkg::ROW_LAST);
    end
  end

  assign out_tvalid   = vo_r;
  assign out_tdata    = data_r;
  assign out_tuser[0] = degen_r;
  assign out_tlast    = last_r;

endmodule

// ----- src/qp2c_checker.sv -----
// Port-level checks for the camera-to-world unit, attached by bind.
// Depends only on the ports of quat_pose_to_cam_to_world_unit.
module qp2c_props (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [0:0]   out_tuser,
  input logic         out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("pose accepted in back-to-back cycles");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd2)) && (out_tdata[1:0] != 2'd3))
    else $error("row index and last disagree");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[129:2] == '0)
    else $error("degenerate row carries nonzero data");

endmodule

bind quat_pose_to_cam_to_world_unit qp2c_props u_qp2c_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
